// ===== sv/qts_pkg.sv =====
// Shared constants and types for the quintic trajectory sample datapath.
package qts_pkg;

   localparam int DEF_FRAC_BITS  = 16;
   localparam int DEF_INDEX_BITS = 16;

   localparam int VALUE_BITS = 32;
   localparam int DELTA_BITS = VALUE_BITS + 1;
   localparam int SUM_BITS   = VALUE_BITS + 3;

   // blend factor is unsigned Q1.24
   localparam int BLEND_SHIFT = 24;
   localparam int TAU_BITS    = BLEND_SHIFT + 1;
   localparam logic [TAU_BITS-1:0] BLEND_ONE = TAU_BITS'(1) << BLEND_SHIFT;
   localparam int ROUND_HALF  = 1 << (BLEND_SHIFT - 1);
   localparam int POLY_BITS   = BLEND_SHIFT + 4;
   localparam int POLY_BASE   = 10 << BLEND_SHIFT;

   // a full turn is 45 * 2^(FRAC_BITS+3)
   localparam int TURN_UNITS = 45;
   localparam int TURN_BITS  = 6;

   localparam int BLEND_STAGES = 3;
   localparam int WRAP_STAGES  = 3;

   typedef struct packed {
      logic                last;
      logic [TAU_BITS-1:0] tau;
   } div_out_type;

endpackage

// ===== sv/qts_divider.sv =====
// Pipelined restoring divider: forms tau = index / ticks in Q1.24, one bit per stage.
module qts_divider #(
   parameter int INDEX_BITS = qts_pkg::DEF_INDEX_BITS
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [INDEX_BITS-1:0]   index,
   input  logic [INDEX_BITS-1:0]   ticks,
   output qts_pkg::div_out_type    div_out
);
   import qts_pkg::*;

   localparam int STEPS = BLEND_SHIFT;

   logic [INDEX_BITS-1:0] rem_ff [STEPS];
   logic [INDEX_BITS-1:0] rem_in [STEPS];
   logic [INDEX_BITS-1:0] den_ff [STEPS];
   logic [INDEX_BITS-1:0] den_in [STEPS];
   logic [STEPS-1:0]      quo_ff [STEPS];
   logic [STEPS-1:0]      quo_in [STEPS];
   logic                  sat_ff [STEPS];
   logic                  sat_in [STEPS];

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [INDEX_BITS-1:0] r_src;
      logic [INDEX_BITS-1:0] d_src;
      logic [STEPS-1:0]      q_src;
      logic                  s_src;
      logic [INDEX_BITS:0]   r_shift;
      logic                  ge;

      if (j == 0) begin : g_first
         // saturated covers zero length and any index at or past the end
         assign r_src = index;
         assign d_src = ticks;
         assign q_src = '0;
         assign s_src = (ticks == '0) || (index >= ticks);
      end else begin : g_next
         assign r_src = rem_ff[j-1];
         assign d_src = den_ff[j-1];
         assign q_src = quo_ff[j-1];
         assign s_src = sat_ff[j-1];
      end

      assign r_shift   = {r_src, 1'b0};
      assign ge        = r_shift >= {1'b0, d_src};
      assign rem_in[j] = ge ? INDEX_BITS'(r_shift - {1'b0, d_src}) : r_shift[INDEX_BITS-1:0];
      assign quo_in[j] = {q_src[STEPS-2:0], ge};
      assign den_in[j] = d_src;
      assign sat_in[j] = s_src;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         quo_ff <= quo_in;
         sat_ff <= sat_in;
      end
   end

   assign div_out.last = sat_ff[STEPS-1];
   assign div_out.tau  = sat_ff[STEPS-1] ? BLEND_ONE : {1'b0, quo_ff[STEPS-1]};

endmodule

// ===== sv/qts_blend.sv =====
// Quintic blend s = 10t^3 - 15t^4 + 6t^5 in three multiply stages.
module qts_blend (
   input  logic                          clock,
   input  logic                          en,
   input  logic [qts_pkg::TAU_BITS-1:0]  tau,
   output logic [qts_pkg::TAU_BITS-1:0]  s
);
   import qts_pkg::*;

   localparam int SQ_BITS   = 2 * TAU_BITS;
   localparam int PR_BITS   = TAU_BITS + POLY_BITS;
   localparam int SRAW_BITS = PR_BITS - BLEND_SHIFT;
   localparam int PCW       = POLY_BITS + 2;

   logic [TAU_BITS-1:0]  tau_ff;
   logic [TAU_BITS-1:0]  t2_ff;
   logic [TAU_BITS-1:0]  t2_in;
   logic [TAU_BITS-1:0]  t3_ff;
   logic [TAU_BITS-1:0]  t3_in;
   logic [POLY_BITS-1:0] poly_ff;
   logic [POLY_BITS-1:0] poly_in;
   logic [TAU_BITS-1:0]  s_ff;
   logic [TAU_BITS-1:0]  s_in;

   logic [SQ_BITS-1:0]   sq;
   logic [SQ_BITS-1:0]   cube;
   logic signed [PCW-1:0] pw;
   logic [PR_BITS-1:0]   pr;
   logic [SRAW_BITS-1:0] s_raw;

   // stage 1: t^2
   assign sq    = tau * tau;
   assign t2_in = TAU_BITS'((sq + SQ_BITS'(ROUND_HALF)) >> BLEND_SHIFT);

   // stage 2: t^3 and the quadratic factor, floored at zero
   assign cube    = t2_ff * tau_ff;
   assign t3_in   = TAU_BITS'((cube + SQ_BITS'(ROUND_HALF)) >> BLEND_SHIFT);
   assign pw      = PCW'(POLY_BASE) - PCW'(tau_ff) * PCW'(15) + PCW'(t2_ff) * PCW'(6);
   assign poly_in = pw[PCW-1] ? '0 : pw[POLY_BITS-1:0];

   // stage 3: product, clamp to one
   assign pr    = t3_ff * poly_ff;
   assign s_raw = SRAW_BITS'((pr + PR_BITS'(ROUND_HALF)) >> BLEND_SHIFT);
   assign s_in  = (s_raw > SRAW_BITS'(BLEND_ONE)) ? BLEND_ONE : s_raw[TAU_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         tau_ff  <= tau;
         t2_ff   <= t2_in;
         t3_ff   <= t3_in;
         poly_ff <= poly_in;
         s_ff    <= s_in;
      end
   end

   assign s = s_ff;

endmodule

// ===== sv/qts_wrap.sv =====
// Angle wrap into (-180, 180] by constant modulo 360, three stages.
module qts_wrap #(
   parameter int IN_BITS   = qts_pkg::DELTA_BITS,
   parameter int FRAC_BITS = qts_pkg::DEF_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [IN_BITS-1:0]   x,
   output logic signed [FRAC_BITS+8:0] y
);
   import qts_pkg::*;

   localparam int OUT_BITS = FRAC_BITS + 9;
   localparam int XL_BITS  = FRAC_BITS + 3;
   localparam int WH       = IN_BITS - XL_BITS;
   localparam int WU       = WH + 1;
   localparam int WM       = WU + 1;
   localparam int WQ       = WU - 5;
   localparam int K        = WU + 6;
   // offset makes the high part non-negative without changing it modulo 45
   localparam longint OFFSET =
      TURN_UNITS * (((longint'(1) << (WH - 1)) + TURN_UNITS - 1) / TURN_UNITS);
   localparam longint RECIP = ((longint'(1) << K) + TURN_UNITS - 1) / TURN_UNITS;
   localparam logic [OUT_BITS-1:0] FULL_TURN = OUT_BITS'(360) << FRAC_BITS;
   localparam logic [OUT_BITS-1:0] HALF_TURN = OUT_BITS'(180) << FRAC_BITS;

   logic signed [WH-1:0] xh;
   logic [WU-1:0]        u_in;
   logic [WU-1:0]        u_ff;
   logic [XL_BITS-1:0]   xl_ff;
   logic [WU-1:0]        u2_ff;
   logic [XL_BITS-1:0]   xl2_ff;
   logic [WU+WM-1:0]     qp;
   logic [WQ-1:0]        q_ff;
   logic [WU-1:0]        rr;
   logic [OUT_BITS-1:0]  m;
   logic [OUT_BITS-1:0]  y_in;
   logic [OUT_BITS-1:0]  y_ff;

   assign xh   = x[IN_BITS-1 -: WH];
   assign u_in = WU'(xh) + WU'(OFFSET);

   // quotient by 45 through the reciprocal, exact for this width
   assign qp = u_ff * WM'(RECIP);

   assign rr   = u2_ff - WU'(q_ff) * WU'(TURN_UNITS);
   assign m    = {rr[TURN_BITS-1:0], xl2_ff};
   assign y_in = (m > HALF_TURN) ? m - FULL_TURN : m;

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff   <= u_in;
         xl_ff  <= x[XL_BITS-1:0];
         u2_ff  <= u_ff;
         xl2_ff <= xl_ff;
         q_ff   <= qp[K +: WQ];
         y_ff   <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ===== sv/quintic_trajectory_sample.sv =====
// Throughput: one beat per cycle; the whole pipeline holds while rsp is stalled.
// Depth: 24 divider stages for tau, 3 blend, multiply, round, sum, 3 result wrap, output reg.
// The delta wrap runs beside the divider and does not lengthen the pipeline.
// Reset (synchronous, active high) clears the stage valid bits only; data regs keep
// whatever they hold.
module quintic_trajectory_sample #(
   parameter int  FRAC_BITS  = qts_pkg::DEF_FRAC_BITS,
   parameter int  INDEX_BITS = qts_pkg::DEF_INDEX_BITS,
   localparam int REQ_BITS   = ((2 * qts_pkg::VALUE_BITS + 2 * INDEX_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_value, end_value, sample_index, duration_ticks, zero fill
   input  logic [REQ_BITS-1:0]             req_tdata,
   // is_angle
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // value
   output logic [qts_pkg::VALUE_BITS-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import qts_pkg::*;

   localparam int WRAP_BITS = FRAC_BITS + 9;
   localparam int ST_WRAPA  = 1 + WRAP_STAGES;
   localparam int ST_DSEL   = ST_WRAPA + 1;
   localparam int ST_DIV    = BLEND_SHIFT;
   localparam int ST_BLEND  = ST_DIV + BLEND_STAGES;
   localparam int ST_MUL    = ST_BLEND + 1;
   localparam int ST_RND    = ST_MUL + 1;
   localparam int ST_SUM    = ST_RND + 1;
   localparam int ST_WRAP   = ST_SUM + WRAP_STAGES;
   localparam int ST_OUT    = ST_WRAP + 1;

   localparam int LO_BITS   = 16;
   localparam int HI_BITS   = DELTA_BITS - LO_BITS;
   localparam int PH_BITS   = HI_BITS + TAU_BITS + 1;
   localparam int PL_BITS   = LO_BITS + TAU_BITS;
   localparam int PROD_BITS = DELTA_BITS + TAU_BITS;
   localparam int RS_BITS   = PROD_BITS - BLEND_SHIFT;
   localparam logic signed [WRAP_BITS-1:0] HALF_TURN = WRAP_BITS'(180) << FRAC_BITS;

   logic                          en;
   logic signed [VALUE_BITS-1:0]  req_start;
   logic signed [VALUE_BITS-1:0]  req_end;
   logic [INDEX_BITS-1:0]         req_index;
   logic [INDEX_BITS-1:0]         req_ticks;

   logic                          vld_ff   [1:ST_OUT];
   logic signed [VALUE_BITS-1:0]  start_ff [1:ST_RND];
   logic                          angle_ff [1:ST_WRAP];
   logic signed [DELTA_BITS-1:0]  draw_ff  [1:ST_WRAPA];
   logic signed [DELTA_BITS-1:0]  delta_ff [ST_DSEL:ST_BLEND];
   logic                          last_ff  [ST_DIV+1:ST_OUT];
   logic signed [SUM_BITS-1:0]    xs_ff    [ST_SUM:ST_WRAP];
   logic signed [PH_BITS-1:0]     ph_ff;
   logic signed [PH_BITS-1:0]     ph_in;
   logic [PL_BITS-1:0]            pl_ff;
   logic [PL_BITS-1:0]            pl_in;
   logic signed [RS_BITS-1:0]     rs_ff;
   logic signed [PROD_BITS-1:0]   prod;
   logic signed [PROD_BITS-1:0]   rsum;
   logic [VALUE_BITS-1:0]         value_ff;
   logic [VALUE_BITS-1:0]         value_in;

   div_out_type                   div_out;
   logic [TAU_BITS-1:0]           blend_s;
   logic signed [WRAP_BITS-1:0]   wrap_a;
   logic signed [WRAP_BITS-1:0]   wrap_b;
   logic signed [63:0]            wb_wide;

   assign req_start = req_tdata[0 +: VALUE_BITS];
   assign req_end   = req_tdata[VALUE_BITS +: VALUE_BITS];
   assign req_index = req_tdata[2*VALUE_BITS +: INDEX_BITS];
   assign req_ticks = req_tdata[2*VALUE_BITS+INDEX_BITS +: INDEX_BITS];

   // advance unless the output beat is waiting
   assign en         = !vld_ff[ST_OUT] || rsp_tready;
   assign req_tready = en;

   qts_divider #(
      .INDEX_BITS (INDEX_BITS)
   ) u_divider (
      .clock   (clock),
      .en      (en),
      .index   (req_index),
      .ticks   (req_ticks),
      .div_out (div_out)
   );

   qts_blend u_blend (
      .clock (clock),
      .en    (en),
      .tau   (div_out.tau),
      .s     (blend_s)
   );

   qts_wrap #(
      .IN_BITS   (DELTA_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_wrap_delta (
      .clock (clock),
      .en    (en),
      .x     (draw_ff[1]),
      .y     (wrap_a)
   );

   qts_wrap #(
      .IN_BITS   (SUM_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_wrap_sum (
      .clock (clock),
      .en    (en),
      .x     (xs_ff[ST_SUM]),
      .y     (wrap_b)
   );

   // split delta so each partial product stays narrow
   assign ph_in = $signed(delta_ff[ST_BLEND][DELTA_BITS-1 -: HI_BITS])
                * $signed({1'b0, blend_s});
   assign pl_in = delta_ff[ST_BLEND][LO_BITS-1:0] * blend_s;

   assign prod = (PROD_BITS'(ph_ff) <<< LO_BITS) + PROD_BITS'(pl_ff);
   assign rsum = prod + PROD_BITS'(ROUND_HALF);

   assign wb_wide  = 64'(wrap_b);
   assign value_in = angle_ff[ST_WRAP] ? wb_wide[VALUE_BITS-1:0]
                                       : xs_ff[ST_WRAP][VALUE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= ST_OUT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= req_tvalid;
         for (int i = 2; i <= ST_OUT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         start_ff[1] <= req_start;
         for (int i = 2; i <= ST_RND; i++) start_ff[i] <= start_ff[i-1];

         angle_ff[1] <= req_tuser[0];
         for (int i = 2; i <= ST_WRAP; i++) angle_ff[i] <= angle_ff[i-1];

         draw_ff[1] <= DELTA_BITS'(req_end) - DELTA_BITS'(req_start);
         for (int i = 2; i <= ST_WRAPA; i++) draw_ff[i] <= draw_ff[i-1];

         delta_ff[ST_DSEL] <= angle_ff[ST_WRAPA] ? DELTA_BITS'(wrap_a) : draw_ff[ST_WRAPA];
         for (int i = ST_DSEL + 1; i <= ST_BLEND; i++) delta_ff[i] <= delta_ff[i-1];

         last_ff[ST_DIV+1] <= div_out.last;
         for (int i = ST_DIV + 2; i <= ST_OUT; i++) last_ff[i] <= last_ff[i-1];

         ph_ff <= ph_in;
         pl_ff <= pl_in;
         rs_ff <= rsum[BLEND_SHIFT +: RS_BITS];

         xs_ff[ST_SUM] <= SUM_BITS'(start_ff[ST_RND]) + SUM_BITS'(rs_ff);
         for (int i = ST_SUM + 1; i <= ST_WRAP; i++) xs_ff[i] <= xs_ff[i-1];

         value_ff <= value_in;
      end
   end

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = value_ff;
   assign rsp_tlast  = last_ff[ST_OUT];

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output beat is stalled");

   a_blend_clamped: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_BLEND] |-> blend_s <= BLEND_ONE)
      else $error("blend factor above one");

   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_WRAP] && angle_ff[ST_WRAP] |-> wrap_b > -HALF_TURN && wrap_b <= HALF_TURN)
      else $error("wrapped angle out of range");

endmodule

// ===== verif/quintic_trajectory_sample_chk.sv =====
// Channel monitor for the quintic trajectory sampler: predicts every sample and scores rsp beats.
`timescale 1ns / 100ps
module quintic_trajectory_sample_chk #(
   parameter int FRAC_BITS  = qts_pkg::DEF_FRAC_BITS,
   parameter int INDEX_BITS = qts_pkg::DEF_INDEX_BITS,
   parameter int REQ_BITS   = ((2 * qts_pkg::VALUE_BITS + 2 * INDEX_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // start_value, end_value, sample_index, duration_ticks, zero fill
   input  logic [REQ_BITS-1:0]            req_tdata,
   // is_angle
   input  logic [0:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // value
   input  logic [qts_pkg::VALUE_BITS-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   output int                             errors,
   output int                             pending
);

   localparam int     VB          = qts_pkg::VALUE_BITS;
   localparam int     SHIFT       = qts_pkg::BLEND_SHIFT;
   localparam longint UNITY       = longint'(1) << SHIFT;
   localparam longint HALF_LSB    = longint'(1) << (SHIFT - 1);
   localparam longint HALF_TURN   = longint'(180) << FRAC_BITS;
   localparam longint FULL_TURN   = longint'(360) << FRAC_BITS;
   localparam int     MAX_REPORTS = 10;

   typedef struct packed {
      logic [VB-1:0] value;
      logic          last;
      logic [31:0]   seq;
   } sample_type;

   sample_type  expected_samples[$];
   int unsigned req_seq;

   // floor(x / 2^24 + 1/2)
   function automatic longint round_blend(longint x);
      return (x + HALF_LSB) >>> SHIFT;
   endfunction

   // reduce into (-180, 180] degrees
   function automatic longint wrap_turn(longint x);
      longint r;
      r = x % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      if (r > HALF_TURN) r -= FULL_TURN;
      return r;
   endfunction

   function automatic longint blend_factor(longint idx, longint dur);
      longint tau, t2, t3, poly, s;
      if (dur == 0) begin
         tau = UNITY;
      end else begin
         tau = (idx << SHIFT) / dur;
         if (tau > UNITY) tau = UNITY;
      end
      t2 = (tau * tau + HALF_LSB) >>> SHIFT;
      t3 = (t2 * tau + HALF_LSB) >>> SHIFT;
      poly = 10 * UNITY - 15 * tau + 6 * t2;
      if (poly < 0) poly = 0;
      s = (t3 * poly + HALF_LSB) >>> SHIFT;
      if (s > UNITY) s = UNITY;
      return s;
   endfunction

   function automatic sample_type predict_sample(logic [VB-1:0] start_raw,
                                                 logic [VB-1:0] end_raw,
                                                 logic angle, logic [INDEX_BITS-1:0] idx,
                                                 logic [INDEX_BITS-1:0] dur);
      longint     origin, target, delta, pos, s;
      sample_type r;
      origin = longint'($signed(start_raw));
      target = longint'($signed(end_raw));
      s      = blend_factor(longint'(idx), longint'(dur));
      delta  = target - origin;
      if (angle) begin
         delta = wrap_turn(delta);
         pos   = wrap_turn(origin + round_blend(delta * s));
      end else begin
         pos = origin + round_blend(delta * s);
      end
      r.value = pos[VB-1:0];
      r.last  = (dur == 0) || (idx >= dur);
      r.seq   = '0;
      return r;
   endfunction

   function automatic void flag_mismatch(string what, sample_type want,
                                         logic [VB-1:0] got_value, logic got_last);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s on sample %0d: expected value %h last %b, got value %h last %b",
                  $time, what, want.seq, want.value, want.last, got_value, got_last);
   endfunction

   always @(posedge clock) begin : track
      sample_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = predict_sample(req_tdata[0 +: VB], req_tdata[VB +: VB], req_tuser[0],
                                  req_tdata[2*VB +: INDEX_BITS],
                                  req_tdata[2*VB+INDEX_BITS +: INDEX_BITS]);
            want.seq = req_seq;
            req_seq++;
            expected_samples.insert(expected_samples.size(), want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               want = '0;
               flag_mismatch("unexpected beat", want, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== want.value)
                  flag_mismatch("value mismatch", want, rsp_tdata, rsp_tlast);
               if (rsp_tlast !== want.last)
                  flag_mismatch("last mismatch", want, rsp_tdata, rsp_tlast);
            end
         end
      end
      pending = expected_samples.size();
   end

endmodule

// ===== verif/quintic_trajectory_sample_tb.sv =====
// Stimulus, flow control and verdict for the quintic trajectory sampler.
`timescale 1ns / 100ps
module quintic_trajectory_sample_tb;

   localparam int FRAC_BITS    = qts_pkg::DEF_FRAC_BITS;
   localparam int INDEX_BITS   = qts_pkg::DEF_INDEX_BITS;
   localparam int VB           = qts_pkg::VALUE_BITS;
   localparam int REQ_BITS     = ((2 * VB + 2 * INDEX_BITS + 7) / 8) * 8;
   localparam int DEG          = 1 << FRAC_BITS;
   localparam int SAMPLE_COUNT = 600;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam int MAX_WAIT     = 16;
   localparam int MAX_INDEX    = (1 << INDEX_BITS) - 1;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic [REQ_BITS-1:0] req_tdata  = '0;
   logic [0:0]          req_tuser  = '0;
   logic                rsp_tready = 1'b0;
   logic                req_tready;
   logic                rsp_tvalid;
   logic [VB-1:0]       rsp_tdata;
   logic                rsp_tlast;

   int          errors;
   int          pending;
   int unsigned sent         = 0;
   int unsigned rsp_hold     = 0;
   int unsigned idle_cycles  = 0;
   bit          req_calm     = 1'b0;
   bit          rsp_calm     = 1'b0;
   bit          paused       = 1'b0;

   always #5 clock = ~clock;

   quintic_trajectory_sample #(
      .FRAC_BITS (FRAC_BITS),
      .INDEX_BITS(INDEX_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   quintic_trajectory_sample_chk #(
      .FRAC_BITS (FRAC_BITS),
      .INDEX_BITS(INDEX_BITS),
      .REQ_BITS  (REQ_BITS)
   ) chk (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .errors    (errors),
      .pending   (pending)
   );

   // rsp side: after each beat, stall a random number of cycles
   always @(posedge clock) begin : rsp_flow
      int unsigned n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (!rsp_tready) begin
         if (rsp_hold == 0) rsp_tready <= 1'b1;
         else rsp_hold <= rsp_hold - 1;
      end else if (rsp_tvalid) begin
         n = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (n != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= n - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one beat; keep tvalid high across back-to-back beats
   task automatic send_sample(input logic [VB-1:0] a, input logic [VB-1:0] b,
                              input logic ang, input logic [INDEX_BITS-1:0] idx,
                              input logic [INDEX_BITS-1:0] dur);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'({dur, idx, b, a});
      req_tuser  <= ang;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [VB-1:0] pick_value(int unsigned kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 360 * DEG) - 180 * DEG;
         2: return $urandom_range(0, 2000 * DEG) - 1000 * DEG;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   // walk one move from index 0 to its end, sometimes one step past it
   task automatic run_move();
      logic [VB-1:0] a, b;
      logic          ang;
      int unsigned   d, step, i;
      ang = 1'($urandom_range(0, 1));
      a = pick_value(ang && $urandom_range(0, 4) != 0 ? 1 : $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) b = a + ($urandom_range(0, 2 * DEG) - DEG);
      else b = pick_value(ang && $urandom_range(0, 4) != 0 ? 1 : $urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0:       d = 0;
         1, 2, 3,
         4, 5, 6: d = $urandom_range(1, 20);
         7, 8:    d = $urandom_range(21, 500);
         default: d = $urandom_range(501, MAX_INDEX);
      endcase
      step = (d > 16) ? d / 12 + $urandom_range(0, 3) : 1;
      for (i = 0; i < d; i += step)
         send_sample(a, b, ang, INDEX_BITS'(i), INDEX_BITS'(d));
      send_sample(a, b, ang, INDEX_BITS'(d), INDEX_BITS'(d));
      if (d < MAX_INDEX && $urandom_range(0, 2) == 0)
         send_sample(a, b, ang, INDEX_BITS'(d + 1), INDEX_BITS'(d));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain moves: full-scale deltas, zero duration, ends and past-end indices
      send_sample(32'h8000_0000, 32'h7fff_ffff, 1'b0, 0, 0);
      send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b0, 16'hffff, 16'hffff);
      send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b0, 16'h8000, 16'hffff);
      send_sample(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1, 16'hffff);
      send_sample(0, 32'h7fff_ffff, 1'b0, 16'hffff, 1);
      send_sample(5 * DEG, -7 * DEG, 1'b0, 0, 1);
      send_sample(5 * DEG, -7 * DEG, 1'b0, 1, 2);
      send_sample(-3 * DEG, 9 * DEG, 1'b0, 3, 7);
      send_sample(1, -1, 1'b0, 16'h7fff, 16'hffff);
      send_sample(32'hffff_ffff, 0, 1'b0, 16'hfffe, 16'hffff);
      send_sample(100 * DEG, 100 * DEG, 1'b0, 3, 5);
      // angles: shortest path across the seam, half-turn ties, raw values out of range
      send_sample(0, 270 * DEG, 1'b1, 0, 0);
      send_sample(170 * DEG, -170 * DEG, 1'b1, 1, 2);
      send_sample(-170 * DEG, 170 * DEG, 1'b1, 1, 2);
      send_sample(180 * DEG, 0, 1'b1, 1, 2);
      send_sample(0, 180 * DEG, 1'b1, 2, 2);
      send_sample(-180 * DEG, -180 * DEG, 1'b1, 0, 4);
      send_sample(32'h8000_0000, 32'h7fff_ffff, 1'b1, 5, 9);
      send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b1, 16'hffff, 0);
      send_sample(90 * DEG, -90 * DEG, 1'b1, 16'hffff, 16'hffff);
      hold_until_drained();

      while (sent < SAMPLE_COUNT) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0)
            send_sample($urandom, $urandom, 1'($urandom_range(0, 1)),
                        INDEX_BITS'($urandom_range(0, MAX_INDEX)),
                        INDEX_BITS'($urandom_range(0, MAX_INDEX)));
         else
            run_move();
         if (!paused && sent >= SAMPLE_COUNT / 2) begin
            paused = 1'b1;
            hold_until_drained();
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/qts_pkg.sv
sv/qts_divider.sv
sv/qts_blend.sv
sv/qts_wrap.sv
sv/quintic_trajectory_sample.sv
verif/quintic_trajectory_sample_chk.sv
verif/quintic_trajectory_sample_tb.sv
